FILE: hw/rtl/lzhw_pkg.sv
// Shared constants and transfer types of the LZ history window.
package lzhw_pkg;

   localparam int WINDOW_SIZE = 4096;
   localparam int ADDR_W      = $clog2(WINDOW_SIZE);
   localparam int MAX_COPY    = 64;
   localparam int LEN_W       = 7;
   localparam int DIST_W      = 13;
   localparam int BYTE_W      = 8;

   localparam logic CMD_LITERAL = 1'b0;
   localparam logic CMD_COPY    = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] literal_byte;
      logic [DIST_W-1:0] copy_distance;
      logic [LEN_W-1:0]  copy_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture a copy transfer
      logic lit_write;  // append the literal byte
      logic read_en;    // read the source byte
      logic emit;       // append and emit the byte read
   } lzhw_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic copy_go;    // copy transfer with nonzero length
      logic last;       // current byte is the final one of the run
   } lzhw_stat_type;

endpackage

FILE: hw/rtl/lzhw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzhw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/lzhw_ctrl.sv
// Controller state machine of the LZ history window.
module lzhw_ctrl
   import lzhw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  lzhw_stat_type stat,
   output lzhw_cmd_type  cmd,
   output logic          busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      emit_ff, emit_in;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      emit_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && stat.copy_go) begin
               state_in = ST_READ;
               busy_in  = 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
            emit_in  = 1'b1;
         end
         ST_EMIT: begin
            if (stat.last) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         emit_ff  <= emit_in;
      end
   end

   assign cmd.load      = accept && stat.copy_go;
   assign cmd.lit_write = accept && !stat.copy_go;
   assign cmd.read_en   = (state_ff == ST_READ);
   assign cmd.emit      = emit_ff;
   assign busy          = busy_ff;

endmodule

FILE: hw/rtl/lzhw_dp.sv
// Datapath of the LZ history window: pointers, run counter and history RAM.
module lzhw_dp
   import lzhw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_item,
   input  lzhw_cmd_type  cmd,
   output lzhw_stat_type stat,
   output rsp_type       rsp_item
);

   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] rd_ff, rd_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  len_clamped;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] rd_data;

   // A literal transfer with a zero length still counts as a literal; only
   // copy transfers with a zero length do nothing.
   assign len_clamped = (req_item.copy_length > LEN_W'(MAX_COPY)) ? LEN_W'(MAX_COPY)
                                                                  : req_item.copy_length;
   assign stat.copy_go = (req_item.cmd == CMD_COPY) && (req_item.copy_length != '0);
   assign stat.last    = (count_ff == LEN_W'(1));

   // Treat any copy with zero length as a no-op: neither load nor write.
   assign wr_en   = (cmd.lit_write && (req_item.cmd == CMD_LITERAL)) || cmd.emit;
   assign wr_data = cmd.emit ? rd_data : req_item.literal_byte;

   always_comb begin
      wp_in    = wp_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (wr_en) begin
         wp_in = wp_ff + ADDR_W'(1);
      end
      if (cmd.load) begin
         // Distance wraps modulo the window size.
         rd_in    = wp_ff - req_item.copy_distance[ADDR_W-1:0];
         count_in = len_clamped;
      end else if (cmd.emit) begin
         rd_in    = rd_ff + ADDR_W'(1);
         count_in = count_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
      rd_ff    <= rd_in;
      count_ff <= count_in;
   end

   lzhw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_SIZE)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.read_en),
      .rd_addr (rd_ff),
      .rd_data (rd_data)
   );

   assign rsp_item.out_byte = rd_data;
   assign rsp_item.last     = stat.last;

endmodule

FILE: hw/rtl/lz_history_window.sv
// Top level of the LZ history window: controller plus datapath.
//
// Usage: present a transfer on req_item and raise start; it is taken at a
// rising edge where start is high and busy is low.
// A literal transfer (cmd = 0) appends literal_byte at the write position in
// that same cycle and produces no result; busy stays low, so one literal is
// taken every cycle.
// A copy transfer (cmd = 1) reads the byte copy_distance behind the write
// position (distance taken modulo the 4096-byte window), emits it on
// rsp_item with rsp_strobe high for one cycle, and appends it to the window.
// This repeats copy_length times (cut to 64); last marks the final byte.
// Each copied byte takes a read step, which reads the history RAM through its
// registered read port, then an emit step, which writes the byte back and
// emits it. A copy keeps busy high until its last byte is emitted, and its
// first byte shows after the read step. A copy of length zero does nothing.
// Reset clears the write position and the controller; the window contents
// stay as they were and are meaningful only once written.
// The receiver cannot stall: each result is taken the cycle it is shown.
module lz_history_window
   import lzhw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   lzhw_cmd_type  cmd;
   lzhw_stat_type stat;

   // Sequence the read and emit steps of each copied byte.
   lzhw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Hold the pointers, the run counter and the history RAM.
   lzhw_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

   // Mark a result during the emit step of each copied byte.
   assign rsp_strobe = cmd.emit;

endmodule
